>>> rtl/psfp_pkg.sv
package psfp_pkg;

   // Frame layout
   localparam logic [7:0]  SYNC_FIRST  = 8'h42;
   localparam logic [7:0]  SYNC_SECOND = 8'h4D;
   localparam logic [15:0] FRAME_LEN   = 16'd28;
   localparam logic [4:0]  POS_LENGTH  = 5'd3;
   localparam logic [4:0]  POS_CAP_LO  = 5'd5;
   localparam logic [4:0]  POS_CAP_HI  = 5'd27;
   localparam logic [4:0]  POS_SUM_END = 5'd30;
   localparam logic [4:0]  POS_LAST    = 5'd31;

   // Captured words
   localparam int NUM_VALUES = 12;
   localparam int IDX_W      = 4;
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_VALUES - 1);
   localparam logic [15:0]      BAD_VALUE = 16'hFFFF;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   typedef logic [NUM_VALUES-1:0][15:0] values_type;

   // Frame completion status from the parser
   typedef struct packed {
      logic at_last;   // parser waits for the checksum low byte
      logic done;      // final byte of a frame is being taken
      logic ok;        // checksum matched
   } frame_status_type;

endpackage

>>> rtl/particle_sensor_frame_parser.sv
// The first result transfer of a frame is offered in the cycle after its final byte is taken.
// Throughput: one byte per cycle; twelve result transfers per 32-byte frame, drained
// from a result bank while the next frame's bytes arrive. The final byte of a frame
// stalls only while the previous frame's results have not all been taken.
// Reset (synchronous, active high) returns the parser to the first header byte and
// empties the result bank.
module particle_sensor_frame_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psfp_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] data_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [3:0] quantity_index,
                                                         // [19:4] quantity_value, rest zero
   output logic                              rsp_tuser,  // [0] frame_ok
   output logic                              rsp_tlast   // last_of_frame
);
   import psfp_pkg::*;

   frame_status_type  status;
   values_type        values;
   logic              req_take;
   logic              rsp_take;
   logic              load;
   logic              busy_ff, busy_in;
   logic              ok_ff, ok_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       bank_ff [NUM_VALUES];

   assign req_tready = !(status.at_last && busy_ff);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign load       = req_take && status.done;

   psfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .data_byte (req_tdata),
      .status    (status),
      .values    (values)
   );

   // Load the bank on a completed frame, then step through it per transfer
   always_comb begin
      busy_in = busy_ff;
      ok_in   = ok_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         ok_in   = status.ok;
         cnt_in  = '0;
      end else if (rsp_take) begin
         if (cnt_ff == IDX_LAST) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ok_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ok_ff   <= ok_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Hold the frame's words, replaced by the failure marker on a bad checksum
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < NUM_VALUES; k++) begin
            bank_ff[k] <= status.ok ? values[k] : BAD_VALUE;
         end
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {(RSP_DATA_W - IDX_W - 16)'(0), bank_ff[cnt_ff], cnt_ff};
   assign rsp_tuser  = ok_ff;
   assign rsp_tlast  = (cnt_ff == IDX_LAST);

endmodule

>>> rtl/psfp_parse.sv
module psfp_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [7:0]                 data_byte,
   output psfp_pkg::frame_status_type status,
   output psfp_pkg::values_type       values
);
   import psfp_pkg::*;

   logic [4:0]       pos_ff, pos_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      sum_ff, sum_in;
   logic [15:0]      cap_ff [NUM_VALUES];
   logic [15:0]      word;
   logic [4:0]       cap_off;
   logic [IDX_W-1:0] cap_idx;
   logic             cap_we;
   logic             done;

   assign word    = {held_ff, data_byte};
   assign cap_off = pos_ff - POS_CAP_LO;
   assign cap_idx = cap_off[IDX_W:1];
   assign cap_we  = take && pos_ff[0] && (pos_ff >= POS_CAP_LO) && (pos_ff <= POS_CAP_HI);

   // Advance position, header checks and checksum accumulation
   always_comb begin
      pos_in  = pos_ff;
      held_in = held_ff;
      sum_in  = sum_ff;
      done    = 1'b0;
      if (take) begin
         priority if ((pos_ff == 5'd0 && data_byte != SYNC_FIRST) ||
                      (pos_ff == 5'd1 && data_byte != SYNC_SECOND)) begin
            pos_in = '0;
            sum_in = '0;
         end else if (pos_ff == POS_LENGTH && word != FRAME_LEN) begin
            pos_in = '0;
            sum_in = '0;
         end else if (pos_ff == POS_LAST) begin
            pos_in = '0;
            sum_in = '0;
            done   = 1'b1;
         end else begin
            if (!pos_ff[0]) begin
               held_in = data_byte;
            end
            if (pos_ff < POS_SUM_END) begin
               sum_in = sum_ff + 16'(data_byte);
            end
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         held_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         sum_ff  <= sum_in;
      end
   end

   // Capture each data word on its low byte
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_ff[cap_idx] <= word;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_VALUES; k++) begin
         values[k] = cap_ff[k];
      end
   end

   assign status.at_last = (pos_ff == POS_LAST);
   assign status.done    = done;
   assign status.ok      = (word == sum_ff);

endmodule
